@@ hdl/gri_pkg.sv @@
// Package for the gyro rate angle integrator: constants, payload structs,
// state and op codes, and the full-scale gain table.
// Used by every module under hdl/.
package gri_pkg;

    // Calibration round length in samples (1 to 64).
    localparam int CALIB_SAMPLES = 40;
    localparam int CNT_W = (CALIB_SAMPLES > 1) ? $clog2(CALIB_SAMPLES) : 1;

    // Field widths.
    localparam int RATE_W  = 16;
    localparam int TIME_W  = 32;
    localparam int DEG_W   = 24;
    localparam int ACC_W   = 48;
    localparam int SUM_W   = 23;
    localparam int SCALE_W = 33;

    // Shared multiplier of each axis: signed A by signed B.
    localparam int MA_W = 25;
    localparam int MB_W = 34;
    localparam int MP_W = MA_W + MB_W;
    localparam int P_W   = 49;
    localparam int LO_W  = 57;
    localparam int INC_W = 51;
    localparam int ACC_SUM_W = INC_W + 1;

    // Division of the calibration sum by CALIB_SAMPLES as a multiply by a
    // rounded-up reciprocal; exact for magnitudes below 2^23.
    localparam int DIV_SHIFT = 30;
    localparam int DIV_W     = DIV_SHIFT + 1;
    localparam logic [DIV_W-1:0] DIV_RECIP =
        DIV_W'(((64'd1 << DIV_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Request codes on the input.
    localparam logic REQ_CALIB = 1'b0;
    localparam logic REQ_MEAS  = 1'b1;

    typedef enum logic {
        OP_CALIB,
        OP_MEAS
    } t_gri_op;

    typedef enum logic [1:0] {
        FSR_250,
        FSR_500,
        FSR_1000,
        FSR_2000
    } t_gri_fsr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMMIT
    } t_gri_state;

    typedef struct packed {
        logic                     req_type;
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
        logic [TIME_W-1:0]        time_us;
    } t_gri_item;

    typedef struct packed {
        logic signed [DEG_W-1:0] angle_x_deg;
        logic signed [DEG_W-1:0] angle_y_deg;
        logic signed [DEG_W-1:0] angle_z_deg;
        logic                    offsets_valid;
    } t_gri_result;

    typedef struct packed {
        t_gri_op                  op;
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
        logic [TIME_W-1:0]        time_us;
    } t_gri_cmd;

    typedef struct packed {
        t_gri_state step;
        t_gri_op    op;
        logic       round_start;
        logic       round_end;
        logic       commit;
    } t_gri_lane_ctl;

    // round(2^56 / (sensitivity * 10^6)) for each range.
    function automatic logic [SCALE_W-1:0] scale_factor(input t_gri_fsr fsr);
        logic [SCALE_W-1:0] m;
        unique case (fsr)
            FSR_250:  m = 33'd550057970;
            FSR_500:  m = 33'd1100115940;
            FSR_1000: m = 33'd2196877867;
            FSR_2000: m = 33'd4393755734;
        endcase
        return m;
    endfunction

endpackage

@@ hdl/gyro_rate_angle_integrator.sv @@
// Channel   Direction  Handshake                 Beat
// item      in         push / full               gri_pkg::t_gri_item
// result    out        pop / empty               gri_pkg::t_gri_result
// config    in         i_cfg_we, no wait         full-scale range code
//
// Each item passes four steps in the back end: three steps of the per-axis
// multiplier and one commit step, which waits while the result register is
// full; the back end takes the next item only as the last one commits.
// Reset is synchronous and clears angles, offsets, calibration state and range.
// A stalled result is held in its register while the front and queue keep taking
// up to three further items.
module gyro_rate_angle_integrator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  gri_pkg::t_gri_item    i_item,
    output logic                  full,
    output gri_pkg::t_gri_result  o_result,
    output logic                  empty,
    input  logic                  pop,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_wdata
);
    import gri_pkg::*;

    logic     w_q_push;
    logic     w_q_full;
    logic     w_q_pop;
    logic     w_q_empty;
    t_gri_cmd w_front_cmd;
    t_gri_cmd w_q_cmd;

    gri_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_cmd  (w_front_cmd)
    );

    gri_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_cmd),
        .o_empty (w_q_empty)
    );

    gri_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_q_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

@@ hdl/gri_front.sv @@
// Front end of the gyro integrator: input register and request decode.
// Feeds gri_queue; depends on gri_pkg.
module gri_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  gri_pkg::t_gri_item  i_item,
    output logic                o_full,
    input  logic                i_q_full,
    output logic                o_q_push,
    output gri_pkg::t_gri_cmd   o_q_cmd
);
    import gri_pkg::*;

    logic     r_valid;
    t_gri_cmd r_cmd;
    t_gri_cmd w_cmd;
    logic     w_accept;

    assign o_q_push = r_valid && !i_q_full;
    assign o_full   = r_valid && i_q_full;
    assign w_accept = i_push && !o_full;
    assign o_q_cmd  = r_cmd;

    always_comb begin
        w_cmd.rate_x  = i_item.rate_x;
        w_cmd.rate_y  = i_item.rate_y;
        w_cmd.rate_z  = i_item.rate_z;
        w_cmd.time_us = i_item.time_us;
        unique case (i_item.req_type)
            REQ_CALIB: w_cmd.op = OP_CALIB;
            REQ_MEAS:  w_cmd.op = OP_MEAS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

@@ hdl/gri_queue.sv @@
// Short command queue between the front and the back of the integrator.
// Depends on gri_pkg for the command type and depth.
module gri_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gri_pkg::t_gri_cmd  i_data,
    output logic               o_full,
    input  logic               i_pop,
    output gri_pkg::t_gri_cmd  o_data,
    output logic               o_empty
);
    import gri_pkg::*;

    t_gri_cmd          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ hdl/gri_axis.sv @@
// One axis of the integrator: offset, calibration sum and angle accumulator,
// with a shared multiplier stepped by the back-end sequencer. Uses gri_pkg.
module gri_axis (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gri_pkg::t_gri_lane_ctl         i_ctl,
    input  logic signed [gri_pkg::RATE_W-1:0] i_rate,
    input  logic [gri_pkg::TIME_W-1:0]     i_dt,
    input  logic [gri_pkg::SCALE_W-1:0]    i_scale,
    output logic signed [gri_pkg::DEG_W-1:0] o_deg
);
    import gri_pkg::*;

    logic signed [ACC_W-1:0]  r_acc;
    logic [RATE_W-1:0]        r_bias;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  r_sum_n;
    logic signed [P_W-1:0]    r_p;
    logic [LO_W-1:0]          r_lo;
    logic signed [INC_W-1:0]  r_inc;
    logic [RATE_W-1:0]        r_avg;

    logic signed [RATE_W-1:0]    w_corr;
    logic [SUM_W-1:0]            w_sum_abs;
    logic signed [MA_W-1:0]      w_a;
    logic signed [MB_W-1:0]      w_b;
    logic signed [MP_W-1:0]      w_prod;
    logic signed [MP_W-1:0]      w_shift;
    logic [SUM_W-1:0]            w_quot;
    logic signed [SUM_W-1:0]     w_avg;
    logic signed [ACC_SUM_W-1:0] w_acc_sum;
    logic signed [ACC_W-1:0]     w_acc_sat;
    logic signed [ACC_W-1:0]     n_acc;
    logic                        w_round_up;

    assign w_corr    = i_rate - $signed(r_bias);
    assign w_sum_abs = r_sum_n[SUM_W-1] ? SUM_W'(-r_sum_n) : r_sum_n;

    // Measurement: corrected rate times dt, then that product times the gain
    // in a low and a high half. Calibration: |sum| times the reciprocal.
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (i_ctl.step)
            ST_MUL0: begin
                w_a = MA_W'(w_corr);
                w_b = {{(MB_W-TIME_W){1'b0}}, i_dt};
            end
            ST_MUL1: begin
                if (i_ctl.op == OP_MEAS) begin
                    w_a = {1'b0, r_p[MA_W-2:0]};
                    w_b = {{(MB_W-SCALE_W){1'b0}}, i_scale};
                end else begin
                    w_a = {{(MA_W-SUM_W){1'b0}}, w_sum_abs};
                    w_b = {{(MB_W-DIV_W){1'b0}}, DIV_RECIP};
                end
            end
            ST_MUL2: begin
                w_a = r_p[P_W-1:MA_W-1];
                w_b = {{(MB_W-SCALE_W){1'b0}}, i_scale};
            end
            default: ;
        endcase
    end

    assign w_prod = w_a * w_b;

    // floor((hi * 2^24 + lo) / 2^32) taken as floor((hi + floor(lo / 2^24)) / 2^8).
    assign w_shift = (w_prod + $signed({{(MP_W-LO_W+MA_W-1){1'b0}}, r_lo[LO_W-1:MA_W-1]}))
                     >>> (32 - (MA_W - 1));

    assign w_quot = SUM_W'(r_lo >> DIV_SHIFT);
    assign w_avg  = r_sum_n[SUM_W-1] ? -$signed(w_quot) : $signed(w_quot);

    assign w_acc_sum = ACC_SUM_W'(r_acc) + ACC_SUM_W'(r_inc);

    always_comb begin
        if (w_acc_sum[ACC_SUM_W-1:ACC_W-1] == {(ACC_SUM_W-ACC_W+1){w_acc_sum[ACC_SUM_W-1]}})
        begin
            w_acc_sat = w_acc_sum[ACC_W-1:0];
        end else if (w_acc_sum[ACC_SUM_W-1]) begin
            w_acc_sat = ACC_MIN;
        end else begin
            w_acc_sat = ACC_MAX;
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.commit) begin
            if (i_ctl.op == OP_MEAS) begin
                n_acc = w_acc_sat;
            end else if (i_ctl.round_start) begin
                n_acc = '0;
            end
        end
    end

    // Whole degrees, truncated toward zero.
    assign w_round_up = n_acc[ACC_W-1] && (n_acc[ACC_W-DEG_W-1:0] != '0);
    assign o_deg = n_acc[ACC_W-1:ACC_W-DEG_W] + {{(DEG_W-1){1'b0}}, w_round_up};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_bias <= '0;
            r_sum  <= '0;
        end else begin
            r_acc <= n_acc;
            if (i_ctl.commit && (i_ctl.op == OP_CALIB)) begin
                if (i_ctl.round_end) begin
                    r_bias <= r_avg;
                    r_sum  <= '0;
                end else begin
                    r_sum <= r_sum_n;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.step)
            ST_MUL0: begin
                r_p     <= w_prod[P_W-1:0];
                r_sum_n <= r_sum + SUM_W'(i_rate);
            end
            ST_MUL1: begin
                r_lo <= w_prod[LO_W-1:0];
            end
            ST_MUL2: begin
                r_inc <= w_shift[INC_W-1:0];
                r_avg <= w_avg[RATE_W-1:0];
            end
            default: ;
        endcase
    end

endmodule

@@ hdl/gri_back.sv @@
// Back end of the integrator: sequencer, timestamp and calibration count,
// three axis lanes and the result register. Uses gri_pkg and gri_axis.
module gri_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  gri_pkg::t_gri_cmd     i_q_cmd,
    output logic                  o_q_pop,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_wdata,
    output gri_pkg::t_gri_result  o_result,
    output logic                  o_empty,
    input  logic                  i_pop
);
    import gri_pkg::*;

    t_gri_state        r_state;
    t_gri_state        n_state;
    t_gri_cmd          r_cmd;
    logic [CNT_W-1:0]  r_count;
    logic [TIME_W-1:0] r_last_time;
    logic              r_bias_ready;
    t_gri_fsr          r_fsr;
    logic              r_out_valid;
    t_gri_result       r_out;

    logic                     w_out_free;
    logic                     w_commit;
    logic                     w_pop_q;
    t_gri_lane_ctl            w_ctl;
    logic [TIME_W-1:0]        w_dt;
    logic [SCALE_W-1:0]       w_scale;
    logic signed [DEG_W-1:0]  w_deg_x;
    logic signed [DEG_W-1:0]  w_deg_y;
    logic signed [DEG_W-1:0]  w_deg_z;
    logic                     w_ready_next;

    assign w_out_free = !r_out_valid || i_pop;
    assign w_commit   = (r_state == ST_COMMIT) && w_out_free;
    assign w_dt       = r_cmd.time_us - r_last_time;
    assign w_scale    = scale_factor(r_fsr);

    assign w_ctl.step        = r_state;
    assign w_ctl.op          = r_cmd.op;
    assign w_ctl.round_start = (r_count == '0);
    assign w_ctl.round_end   = (r_count == CNT_W'(CALIB_SAMPLES - 1));
    assign w_ctl.commit      = w_commit;

    assign w_ready_next = r_bias_ready || ((r_cmd.op == OP_CALIB) && w_ctl.round_end);

    always_comb begin
        n_state = r_state;
        w_pop_q = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    w_pop_q = 1'b1;
                    n_state = ST_MUL0;
                end
            end
            ST_MUL0: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_COMMIT;
            ST_COMMIT: begin
                // The next command starts in the same cycle as this one commits.
                if (w_commit) begin
                    if (!i_q_empty) begin
                        w_pop_q = 1'b1;
                        n_state = ST_MUL0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_q_pop = w_pop_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_q) begin
            r_cmd <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_last_time  <= '0;
            r_bias_ready <= 1'b0;
            r_fsr        <= FSR_250;
        end else begin
            if (i_cfg_we) begin
                r_fsr <= t_gri_fsr'(i_cfg_wdata);
            end
            if (w_commit) begin
                if (r_cmd.op == OP_CALIB) begin
                    if (w_ctl.round_start) begin
                        r_last_time <= r_cmd.time_us;
                    end
                    if (w_ctl.round_end) begin
                        r_count      <= '0;
                        r_bias_ready <= 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end else begin
                    r_last_time <= r_cmd.time_us;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out.angle_x_deg   <= w_deg_x;
            r_out.angle_y_deg   <= w_deg_y;
            r_out.angle_z_deg   <= w_deg_z;
            r_out.offsets_valid <= w_ready_next;
        end
    end

    assign o_result = r_out;
    assign o_empty  = !r_out_valid;

    gri_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_rate  (r_cmd.rate_x),
        .i_dt    (w_dt),
        .i_scale (w_scale),
        .o_deg   (w_deg_x)
    );

    gri_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_rate  (r_cmd.rate_y),
        .i_dt    (w_dt),
        .i_scale (w_scale),
        .o_deg   (w_deg_y)
    );

    gri_axis u_axis_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_rate  (r_cmd.rate_z),
        .i_dt    (w_dt),
        .i_scale (w_scale),
        .o_deg   (w_deg_z)
    );

endmodule

@@ hdl/gri_checker.sv @@
// Port-level checks for the gyro integrator, bound to the top level.
// Depends on gri_pkg for the result type.
module gri_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  push,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input gri_pkg::t_gri_result  o_result
);
    import gri_pkg::*;

    logic [3:0] r_outstanding;
    logic       r_seen_ready;

    // Items taken in whose results have not yet been popped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
            r_seen_ready  <= 1'b0;
        end else begin
            r_outstanding <= r_outstanding + {3'd0, push && !full} - {3'd0, pop && !empty};
            if (pop && !empty && o_result.offsets_valid) begin
                r_seen_ready <= 1'b1;
            end
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue flags not cleared by reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed before it was popped");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty || full) |-> r_outstanding != 4'd0)
        else $error("result or back-pressure without an item in flight");

    a_not_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding == 4'd0 |=> empty)
        else $error("result appeared one cycle after an idle push");

    a_offsets_stay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && r_seen_ready |-> o_result.offsets_valid)
        else $error("offsets_valid dropped after a completed calibration");

endmodule

bind gyro_rate_angle_integrator gri_checker u_gri_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

@@ test/gyro_rate_angle_integrator_test.sv @@
// Self-checking testbench for gyro_rate_angle_integrator: queued stimulus, a driver,
// a monitor with a built-in angle predictor, and random stalls on both sides.
// Depends on gri_pkg and the RTL under hdl/.
module gyro_rate_angle_integrator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gri_pkg::*;

    localparam int CYCLE_LIMIT      = 300000;
    localparam int DRAIN_CYCLES     = 12;
    localparam int LONG_HOLD_AFTER  = 400;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS      = 250;
    localparam int RANDOM_PHASES    = 6;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        pop         = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_wdata = 2'b00;
    t_gri_item   i_item      = '0;
    t_gri_result o_result;
    logic        full;
    logic        empty;

    gyro_rate_angle_integrator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .o_result    (o_result),
        .empty       (empty),
        .pop         (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state, mirroring the block after reset.
    logic signed [ACC_W-1:0] acc_q [3]      = '{default: '0};
    logic [RATE_W-1:0]       bias_q [3]     = '{default: '0};
    int                      calib_sum_q [3] = '{default: 0};
    int                      calib_cnt_q    = 0;
    logic [TIME_W-1:0]       last_us_q      = '0;
    logic                    offsets_ok_q   = 1'b0;
    t_gri_fsr                range_q        = FSR_250;

    t_gri_item   pending_samples [$];
    t_gri_result expected_angles [$];
    t_gri_result want;

    int items_queued = 0;
    int items_taken  = 0;
    int mismatches   = 0;
    int cycle_count  = 0;

    logic item_beat      = 1'b0;
    logic result_beat    = 1'b0;
    int   send_gap       = 0;
    int   recv_gap       = 0;
    int   send_gap_max   = 0;
    int   recv_gap_max   = 0;
    int   hold_left      = 0;
    int   rx_beats       = 0;
    logic long_hold_done = 1'b0;

    // Generator state: running timestamp, position within a calibration round
    // and the at-rest reading that the current round calibrates against.
    logic [TIME_W-1:0] t_gen  = '0;
    int                round_pos = 0;
    int                rest_x = 0;
    int                rest_y = 0;
    int                rest_z = 0;

    function automatic t_gri_result integrate_sample(input t_gri_item it);
        logic signed [RATE_W-1:0] rate [3];
        logic signed [RATE_W-1:0] corr;
        logic [TIME_W-1:0]        dt;
        logic [SCALE_W-1:0]       gain;
        logic signed [95:0]       prod;
        logic signed [63:0]       sum;
        longint                   deg [3];
        t_gri_result              r;
        rate[0] = it.rate_x;
        rate[1] = it.rate_y;
        rate[2] = it.rate_z;
        if (it.req_type == REQ_CALIB) begin
            // The first sample of a round restarts the angles and the time base.
            if (calib_cnt_q == 0) begin
                for (int i = 0; i < 3; i++) acc_q[i] = '0;
                last_us_q = it.time_us;
            end
            for (int i = 0; i < 3; i++) calib_sum_q[i] += rate[i];
            calib_cnt_q++;
            if (calib_cnt_q >= CALIB_SAMPLES) begin
                for (int i = 0; i < 3; i++) begin
                    bias_q[i] = 16'(calib_sum_q[i] / CALIB_SAMPLES);
                    calib_sum_q[i] = 0;
                end
                calib_cnt_q = 0;
                offsets_ok_q = 1'b1;
            end
        end else begin
            dt = it.time_us - last_us_q;
            last_us_q = it.time_us;
            case (range_q)
                FSR_250:  gain = 33'd550057970;
                FSR_500:  gain = 33'd1100115940;
                FSR_1000: gain = 33'd2196877867;
                default:  gain = 33'd4393755734;
            endcase
            for (int i = 0; i < 3; i++) begin
                corr = rate[i] - bias_q[i];
                prod = corr;
                prod = prod * $signed({64'd0, dt}) * $signed({63'd0, gain});
                // Arithmetic shift floors, so negative increments round down.
                sum = acc_q[i] + (prod >>> 32);
                if (sum > ACC_MAX)
                    acc_q[i] = ACC_MAX;
                else if (sum < ACC_MIN)
                    acc_q[i] = ACC_MIN;
                else
                    acc_q[i] = sum[ACC_W-1:0];
            end
        end
        for (int i = 0; i < 3; i++) deg[i] = longint'(acc_q[i]) / 64'sd16777216;
        r.angle_x_deg   = deg[0][DEG_W-1:0];
        r.angle_y_deg   = deg[1][DEG_W-1:0];
        r.angle_z_deg   = deg[2][DEG_W-1:0];
        r.offsets_valid = offsets_ok_q;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [DEG_W-1:0] exp_v,
                               input logic [DEG_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, what, $signed(exp_v), $signed(got_v));
            mismatches++;
        end
    endtask

    // Monitor: predicts on every accepted input beat and checks every result beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_beat   <= 1'b0;
            result_beat <= 1'b0;
        end else begin
            item_beat   <= push && !full;
            result_beat <= pop && !empty;
            if (i_cfg_we)
                range_q = t_gri_fsr'(i_cfg_wdata);
            if (push && !full) begin
                expected_angles.push_back(integrate_sample(i_item));
                items_taken++;
            end
            if (pop && !empty) begin
                if (expected_angles.size() == 0) begin
                    $display("%0t ns: result beat with none expected, actual %p",
                             $time, o_result);
                    mismatches++;
                end else begin
                    want = expected_angles.pop_front();
                    check_field("angle_x_deg", want.angle_x_deg, o_result.angle_x_deg);
                    check_field("angle_y_deg", want.angle_y_deg, o_result.angle_y_deg);
                    check_field("angle_z_deg", want.angle_z_deg, o_result.angle_z_deg);
                    check_field("offsets_valid", DEG_W'(want.offsets_valid),
                                DEG_W'(o_result.offsets_valid));
                end
            end
        end
    end

    // Driver: offers the next pending sample after a random number of idle cycles.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!push || item_beat) begin
                if (send_gap > 0) begin
                    push     <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_samples.size() > 0) begin
                    i_item   <= pending_samples.pop_front();
                    push     <= 1'b1;
                    send_gap <= $urandom_range(0, send_gap_max);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result side: random pop gaps, plus one long hold-off while the sender keeps
    // offering, so that the block fills and pushes back on its input.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (result_beat)
                rx_beats <= rx_beats + 1;
            if (hold_left > 0) begin
                pop       <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (result_beat && !long_hold_done && rx_beats >= LONG_HOLD_AFTER
                         && pending_samples.size() > 8) begin
                pop            <= 1'b0;
                hold_left      <= LONG_HOLD_CYCLES;
                long_hold_done <= 1'b1;
            end else if (!pop || result_beat) begin
                if (recv_gap > 0) begin
                    pop      <= 1'b0;
                    recv_gap <= recv_gap - 1;
                end else begin
                    pop      <= 1'b1;
                    recv_gap <= $urandom_range(0, recv_gap_max);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int jitter(input int centre, input int spread);
        return centre + int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic int any_rate();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic logic [TIME_W-1:0] next_stamp();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 90)
            return t_gen + $urandom_range(200, 20000);
        else if (pick < 97)
            return t_gen + $urandom_range(0, 199);
        return $urandom();
    endfunction

    task automatic queue_sample(input logic req, input int x, input int y, input int z,
                                input logic [TIME_W-1:0] stamp);
        t_gri_item it;
        it.req_type = req;
        it.rate_x   = 16'(x);
        it.rate_y   = 16'(y);
        it.rate_z   = 16'(z);
        it.time_us  = stamp;
        pending_samples.push_back(it);
        items_queued++;
        t_gen = stamp;
        if (req == REQ_CALIB)
            round_pos = (round_pos + 1) % CALIB_SAMPLES;
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || expected_angles.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_range(input t_gri_fsr r);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= r;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly complete calibration rounds followed by measurement bursts, with
    // some rounds interrupted by measurements and fully random samples mixed in.
    task automatic fill_phase(input int count);
        int start;
        int pick;
        int span;
        int spread;
        start = items_queued;
        while (items_queued - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                if ($urandom_range(0, 4) == 0) begin
                    rest_x = any_rate();
                    rest_y = any_rate();
                    rest_z = any_rate();
                end else begin
                    rest_x = jitter(0, 1500);
                    rest_y = jitter(0, 1500);
                    rest_z = jitter(0, 1500);
                end
                spread = $urandom_range(0, 150);
                do
                    queue_sample(REQ_CALIB, jitter(rest_x, spread), jitter(rest_y, spread),
                                 jitter(rest_z, spread), next_stamp());
                while (round_pos != 0);
            end else if (pick < 80) begin
                case ($urandom_range(0, 3))
                    0:       span = 0;
                    1:       span = 40;
                    2:       span = 3000;
                    default: span = 32767;
                endcase
                repeat ($urandom_range(5, 30))
                    queue_sample(REQ_MEAS, jitter(rest_x, span), jitter(rest_y, span),
                                 jitter(rest_z, span), next_stamp());
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 8))
                    queue_sample(REQ_CALIB, jitter(rest_x, 100), jitter(rest_y, 100),
                                 jitter(rest_z, 100), next_stamp());
            end else begin
                queue_sample(logic'($urandom_range(0, 1)), any_rate(), any_rate(),
                             any_rate(), $urandom());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples at the widest range, where one sample can saturate.
        set_range(FSR_2000);
        // Measurements before any calibration, then a backwards timestamp
        // that wraps, a near-full-span step, a one-microsecond step and a zero step.
        queue_sample(REQ_MEAS, 32767, -32768, 0, 32'd1000);
        queue_sample(REQ_MEAS, -1, 1, -32768, 32'd500);
        queue_sample(REQ_MEAS, 32767, 32767, 32767, 32'hFFFF_FFFF);
        queue_sample(REQ_MEAS, -32768, -32768, -32768, 32'h0000_0000);
        queue_sample(REQ_MEAS, -32768, 32767, -1, 32'h0000_0000);
        queue_sample(REQ_MEAS, -32768, -32768, -32768, 32'h8000_0000);
        queue_sample(REQ_MEAS, -32768, -32768, -32768, 32'h0000_0001);
        // A round starts, is interrupted by measurements, then continues.
        queue_sample(REQ_CALIB, 100, -200, 32767, 32'h1234_5678);
        queue_sample(REQ_CALIB, -32768, 32767, -1, 32'hFFFF_FFFF);
        queue_sample(REQ_MEAS, 1000, -1000, 5, 32'h1234_5678 + 32'd10000);
        queue_sample(REQ_MEAS, -3, 3, 0, 32'h1234_5678 + 32'd10001);
        queue_sample(REQ_CALIB, 0, 0, 0, 32'h5555_5555);
        queue_sample(REQ_MEAS, 21845, -21846, 10922, 32'hAAAA_AAAA);

        for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                1: begin
                    send_gap_max = 0;
                    recv_gap_max = 0;
                    set_range(FSR_250);
                end
                2: begin
                    send_gap_max = 14;
                    recv_gap_max = 14;
                    set_range(FSR_500);
                end
                3: begin
                    send_gap_max = 0;
                    recv_gap_max = 14;
                    set_range(FSR_1000);
                end
                4: begin
                    send_gap_max = 14;
                    recv_gap_max = 0;
                    set_range(FSR_2000);
                end
                5: begin
                    send_gap_max = 3;
                    recv_gap_max = 3;
                    set_range(FSR_250);
                end
                default: begin
                    send_gap_max = 6;
                    recv_gap_max = 9;
                    set_range(FSR_1000);
                end
            endcase
            fill_phase(PHASE_ITEMS);
        end

        wait_drained();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
